>>> design/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; the SYNTH build gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, off while reset is held
`define MBWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked property, checked during reset too
`define MBWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MBWM_ASSERT(label, prop, msg)
`define MBWM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> design/mbwm_pkg.sv
// shared types and constants of the multiplexed bus word memory
// no dependencies
package mbwm_pkg;

  localparam int MEM_BYTES  = 65536;
  localparam int BANK_DEPTH = (MEM_BYTES + 1) / 2;
  localparam int BIDX_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [16:0] MEM_SIZE = 17'(MEM_BYTES);

  typedef logic [BIDX_W-1:0] bidx_t;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_ADDR = 2'd1,
    STEP_FLAG = 2'd2,
    STEP_DATA = 2'd3
  } step_t;

  typedef enum logic {
    REG_WR_LOCK      = 1'b0,
    REG_BYTES_IN_USE = 1'b1
  } reg_idx_t;

  // requests to the even and odd byte banks
  typedef struct packed {
    logic       we_e;
    bidx_t      widx_e;
    logic [7:0] wd_e;
    logic       we_o;
    bidx_t      widx_o;
    logic [7:0] wd_o;
    logic       re;
    bidx_t      ridx_e;
    bidx_t      ridx_o;
  } mem_req_t;

  // per-item info carried alongside the bank read
  typedef struct packed {
    logic read;
    logic odd;
    logic inb;
  } item_t;

endpackage

>>> design/mbwm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mbwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/mbwm_ctrl.sv
// bus handshake state machine, configuration registers and bank requests
// depends on mbwm_pkg
module mbwm_ctrl import mbwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        command,
  input  logic        mode_line,
  input  logic [15:0] bus_in,
  input  logic [15:0] load_address,
  input  logic [7:0]  load_byte,
  input  logic        cfg_write,
  input  reg_idx_t    cfg_index,
  input  logic [16:0] cfg_data,
  output mem_req_t    req,
  output item_t       item
);

  step_t       step_r, step_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        wflag_r, wflag_nxt;
  logic        wr_lock_r;
  logic [16:0] bytes_in_use_r;

  logic [16:0] size_c;
  logic        inb;
  logic        odd;
  bidx_t       idx_lo, idx_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= STEP_IDLE;
      addr_r         <= '0;
      wflag_r        <= 1'b0;
      wr_lock_r      <= 1'b0;
      bytes_in_use_r <= '0;
    end else begin
      step_r  <= step_nxt;
      addr_r  <= addr_nxt;
      wflag_r <= wflag_nxt;
      if (cfg_write) begin
        case (cfg_index)
          REG_WR_LOCK:      wr_lock_r      <= cfg_data[0];
          REG_BYTES_IN_USE: bytes_in_use_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign size_c = (bytes_in_use_r > MEM_SIZE) ? MEM_SIZE : bytes_in_use_r;
  assign inb    = ({1'b0, addr_r} + 17'd1) < size_c;
  assign odd    = addr_r[0];
  assign idx_lo = bidx_t'(addr_r >> 1);
  assign idx_hi = bidx_t'((addr_r >> 1) + 16'd1);

  always_comb begin
    step_nxt   = step_r;
    addr_nxt   = addr_r;
    wflag_nxt  = wflag_r;
    req        = '0;
    req.ridx_e = odd ? idx_hi : idx_lo;
    req.ridx_o = idx_lo;
    item.read  = 1'b0;
    item.odd   = odd;
    item.inb   = inb;
    if (accept) begin
      if (command) begin
        if ({1'b0, load_address} < MEM_SIZE) begin
          if (load_address[0]) begin
            req.we_o   = 1'b1;
            req.widx_o = bidx_t'(load_address >> 1);
            req.wd_o   = load_byte;
          end else begin
            req.we_e   = 1'b1;
            req.widx_e = bidx_t'(load_address >> 1);
            req.wd_e   = load_byte;
          end
        end
      end else begin
        case (step_r)
          STEP_IDLE: begin
            if (mode_line) step_nxt = STEP_ADDR;
          end
          STEP_ADDR: begin
            if (!mode_line) begin
              step_nxt = STEP_IDLE;
            end else begin
              addr_nxt = bus_in;
              step_nxt = STEP_FLAG;
            end
          end
          STEP_FLAG: begin
            wflag_nxt = mode_line;
            step_nxt  = STEP_DATA;
          end
          STEP_DATA: begin
            step_nxt = STEP_IDLE;
            if (wflag_r) begin
              if (!wr_lock_r && inb) begin
                // big-endian: high byte at the lower address
                req.we_e = 1'b1;
                req.we_o = 1'b1;
                if (odd) begin
                  req.widx_o = idx_lo;
                  req.wd_o   = bus_in[15:8];
                  req.widx_e = idx_hi;
                  req.wd_e   = bus_in[7:0];
                end else begin
                  req.widx_e = idx_lo;
                  req.wd_e   = bus_in[15:8];
                  req.widx_o = idx_lo;
                  req.wd_o   = bus_in[7:0];
                end
              end
            end else begin
              req.re    = 1'b1;
              item.read = 1'b1;
            end
          end
          default: step_nxt = STEP_IDLE;
        endcase
      end
    end
  end

endmodule

>>> design/mbwm_out.sv
// read stage and result register: assembles the word and holds it for the receiver
// depends on mbwm_pkg
module mbwm_out import mbwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  item_t       item,
  input  logic [7:0]  rd_e,
  input  logic [7:0]  rd_o,
  input  logic        out_ready,
  output logic        in_ready,
  output logic        s1_valid,
  output logic        out_valid,
  output logic [15:0] out_bus_out,
  output logic        out_drive_valid
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  logic [15:0] bus_out_r, bus_out_nxt;
  logic        drive_r;
  logic        advance;
  logic [15:0] word;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  assign word        = s1_item_r.odd ? {rd_o, rd_e} : {rd_e, rd_o};
  assign bus_out_nxt = (s1_item_r.read && s1_item_r.inb) ? word : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= accept;
      if (advance)  out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_item_r <= item;
    if (advance) begin
      bus_out_r <= bus_out_nxt;
      drive_r   <= s1_item_r.read;
    end
  end

  assign s1_valid        = s1_valid_r;
  assign out_valid       = out_valid_r;
  assign out_bus_out     = bus_out_r;
  assign out_drive_valid = drive_r;

endmodule

>>> design/multiplexed_bus_word_memory.sv
// top level of the multiplexed bus word memory
// depends on mbwm_pkg, mbwm_ctrl, mbwm_ram, mbwm_out and assert_macros.svh
//
// Byte memory behind a four-step multiplexed address/data bus handshake.
// Input channel (in_valid/in_ready): each transfer is either one bus clock
// (in_command 0: in_mode_line, in_bus_in) or a load of one memory byte
// (in_command 1: in_load_address, in_load_byte).
// Result channel (out_valid/out_ready): exactly one result per input transfer,
// in order; out_drive_valid marks a read completion, out_bus_out its word.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 write lock,
// index 1 bytes_in_use; write only while the block is idle.
// Throughput: one item per cycle while the receiver keeps out_ready high.
// A result passes the read stage, with the registered read of the even/odd
// byte banks, and then the output register, where it waits for out_ready.
// Reset (synchronous, rst_n low) returns the handshake to idle and clears
// the control, configuration and valid registers; memory contents are undefined until loaded or written.
// A stalled receiver holds the result; one more item is taken into the read
// stage, then in_ready drops until out_ready returns.
`include "assert_macros.svh"

module multiplexed_bus_word_memory import mbwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_mode_line,
  input  logic [15:0] in_bus_in,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_bus_out,
  output logic        out_drive_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [16:0] cfg_data
);

  logic       in_fire;
  mem_req_t   req;
  item_t      item;
  logic [7:0] rd_e, rd_o;
  logic       s1_valid;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  mbwm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .command      (in_command),
    .mode_line    (in_mode_line),
    .bus_in       (in_bus_in),
    .load_address (in_load_address),
    .load_byte    (in_load_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req),
    .item         (item)
  );

  // even byte addresses
  mbwm_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_e (
    .clk   (clk),
    .we    (req.we_e),
    .waddr (req.widx_e),
    .wdata (req.wd_e),
    .re    (req.re),
    .raddr (req.ridx_e),
    .rdata (rd_e)
  );

  // odd byte addresses
  mbwm_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_o (
    .clk   (clk),
    .we    (req.we_o),
    .waddr (req.widx_o),
    .wdata (req.wd_o),
    .re    (req.re),
    .raddr (req.ridx_o),
    .rdata (rd_o)
  );

  mbwm_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_fire),
    .item            (item),
    .rd_e            (rd_e),
    .rd_o            (rd_o),
    .out_ready       (out_ready),
    .in_ready        (in_ready),
    .s1_valid        (s1_valid),
    .out_valid       (out_valid),
    .out_bus_out     (out_bus_out),
    .out_drive_valid (out_drive_valid)
  );

  `MBWM_ASSERT(a_stall_only_when_full, !in_ready |-> (s1_valid && out_valid && !out_ready), "in_ready low without a full pipeline")
  `MBWM_ASSERT(a_read_enters_stage, req.re |=> s1_valid, "bank read issued without an item in the read stage")
  `MBWM_ASSERT(a_read_needs_transfer, req.re |-> in_fire, "bank read without an input transfer")
  `MBWM_ASSERT(a_quiet_bus, (out_valid && !out_drive_valid) |-> (out_bus_out == 16'd0), "bus driven without a read completion")

endmodule
